// File: hdl/fnq_pkg.sv
// Shared types, constants and lookup functions of the frequency to note quantizer.
package fnq_pkg;

    // Field and register widths.
    localparam int FREQ_W  = 30;
    localparam int BASE_W  = 24;
    localparam int TOL_W   = 24;
    localparam int LIMIT_W = 30;
    localparam int CHAR_W  = 8;
    localparam int SEMI_W  = 4;
    localparam int OCT_OUT_W = 4;

    // Ladder notes may overshoot the 30-bit limit by one bit before they are checked.
    localparam int NOTE_W = FREQ_W + 1;

    // Semitone ratio 2^(1/12) in Q24, and the rounding offset.
    localparam int FRAC_W   = 24;
    localparam int RATIO_W  = 25;
    localparam logic [RATIO_W-1:0] SEMI_Q24 = 25'd17774841;
    localparam logic [FRAC_W-1:0]  HALF_Q24 = 24'd8388608;

    // Default step limit of the ladder.
    localparam int FNQ_MAX_STEPS = 128;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [BASE_W-1:0]  BASE_RESET  = 24'd4286447;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 24'd32768;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 30'd983040000;

    // Register index, taken from the word address.
    typedef enum logic [1:0] {
        REG_BASE_FREQ = 2'd0,
        REG_TUNE_TOL  = 2'd1,
        REG_UPPER_LIM = 2'd2
    } fnq_reg_t;

    // ASCII codes used on the display characters.
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SHARP = 8'h23;
    localparam logic [CHAR_W-1:0] CASE_SHIFT = 8'h20;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_PICK,
        ST_FINISH
    } fnq_state_t;

    // Configuration as seen by the sequencer.
    typedef struct packed {
        logic [BASE_W-1:0]  base_freq;
        logic [TOL_W-1:0]   tune_tolerance;
        logic [LIMIT_W-1:0] upper_limit;
    } fnq_cfg_t;

    // One result item.
    typedef struct packed {
        logic                 in_range;
        logic [SEMI_W-1:0]    semitone;
        logic [OCT_OUT_W-1:0] octave;
        logic                 tune_up;
        logic                 in_tune;
        logic [CHAR_W-1:0]    letter_char;
        logic [CHAR_W-1:0]    accidental_char;
        logic [CHAR_W-1:0]    octave_char;
    } fnq_result_t;

    // Upper-case note letter of a semitone.
    function automatic logic [CHAR_W-1:0] fnq_letter(input logic [SEMI_W-1:0] semi);
        logic [CHAR_W-1:0] ch;
        case (semi)
            4'd0, 4'd1:  ch = 8'h43; // C
            4'd2, 4'd3:  ch = 8'h44; // D
            4'd4:        ch = 8'h45; // E
            4'd5, 4'd6:  ch = 8'h46; // F
            4'd7, 4'd8:  ch = 8'h47; // G
            4'd9, 4'd10: ch = 8'h41; // A
            4'd11:       ch = 8'h42; // B
            default:     ch = CHAR_DASH;
        endcase
        return ch;
    endfunction

    // Sharp marker of a semitone.
    function automatic logic fnq_sharp(input logic [SEMI_W-1:0] semi);
        logic s;
        case (semi)
            4'd1, 4'd3, 4'd6, 4'd8, 4'd10: s = 1'b1;
            default:                       s = 1'b0;
        endcase
        return s;
    endfunction

    // Octave marker digit.
    function automatic logic [CHAR_W-1:0] fnq_oct_digit(input logic [OCT_OUT_W-1:0] oct);
        logic [CHAR_W-1:0] ch;
        case (oct)
            4'd0:    ch = 8'h32;
            4'd1:    ch = 8'h31;
            4'd4:    ch = 8'h31;
            4'd5:    ch = 8'h32;
            4'd6:    ch = 8'h33;
            4'd7:    ch = 8'h34;
            4'd8:    ch = 8'h35;
            4'd9:    ch = 8'h36;
            default: ch = CHAR_DASH;
        endcase
        return ch;
    endfunction

endpackage

// File: hdl/fnq_mul.sv
// Semitone ladder unit: the note register and its rounding multiply by 2^(1/12).
module fnq_mul import fnq_pkg::*; (
    input  logic              aclk,
    input  logic              load,
    input  logic [BASE_W-1:0] load_val,
    input  logic              step,
    output logic [NOTE_W-1:0] note
);

    logic [NOTE_W-1:0]         note_reg;
    logic [NOTE_W-1:0]         note_next;
    logic [NOTE_W+RATIO_W-1:0] prod;

    // One rounded step up the ladder: (note * ratio + half) >> 24.
    assign prod = {{RATIO_W{1'b0}}, note_reg} * {{NOTE_W{1'b0}}, SEMI_Q24}
                + {{(NOTE_W+RATIO_W-FRAC_W){1'b0}}, HALF_Q24};

    always_comb begin
        note_next = note_reg;
        if (load) begin
            note_next = {{(NOTE_W-BASE_W){1'b0}}, load_val};
        end else if (step) begin
            note_next = prod[FRAC_W +: NOTE_W];
        end
    end

    always_ff @(posedge aclk) begin
        note_reg <= note_next;
    end

    assign note = note_reg;

endmodule

// File: hdl/fnq_seq.sv
// Sequencer that climbs the ladder, picks the nearer note and forms the result.
module fnq_seq import fnq_pkg::*; #(
    parameter int MAX_STEPS = FNQ_MAX_STEPS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FREQ_W-1:0] in_freq,
    input  fnq_cfg_t          cfg,
    output logic              res_valid,
    input  logic              res_ready,
    output fnq_result_t       res
);

    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int OCT_W = $clog2(MAX_STEPS / 12 + 2);
    localparam int OCT_X = (OCT_W > OCT_OUT_W) ? OCT_W : OCT_OUT_W;

    fnq_state_t        state_reg, state_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [FREQ_W-1:0] prev_reg, prev_next;
    logic [FREQ_W-1:0] good_reg, good_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SEMI_W-1:0] semi_reg, semi_next;
    logic [OCT_W-1:0]  oct_reg, oct_next;
    logic              oor_reg, oor_next;

    logic              mul_load;
    logic              mul_step;
    logic [NOTE_W-1:0] note;
    logic [FREQ_W-1:0] note_lo;
    logic [FREQ_W-1:0] diff_hi;
    logic [FREQ_W-1:0] diff_lo;
    logic [FREQ_W-1:0] good_diff;
    logic [OCT_X-1:0]  oct_x;
    logic [OCT_OUT_W-1:0] oct_sat;

    // Ladder multiplier holding the current note.
    fnq_mul u_mul (
        .aclk     (aclk),
        .load     (mul_load),
        .load_val (cfg.base_freq),
        .step     (mul_step),
        .note     (note)
    );

    // In the pick state the note has passed the limit check, so it fits 30 bits.
    assign note_lo = note[FREQ_W-1:0];
    assign diff_hi = note_lo - freq_reg;
    assign diff_lo = freq_reg - prev_reg;

    // Output arithmetic on the chosen note.
    assign good_diff = (freq_reg > good_reg) ? (freq_reg - good_reg) : (good_reg - freq_reg);
    assign oct_x     = OCT_X'(oct_reg);
    assign oct_sat   = (oct_x > OCT_X'(15)) ? OCT_OUT_W'(15) : oct_x[OCT_OUT_W-1:0];

    // State register and item registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        freq_reg  <= freq_next;
        prev_reg  <= prev_next;
        good_reg  <= good_next;
        count_reg <= count_next;
        semi_reg  <= semi_next;
        oct_reg   <= oct_next;
        oor_reg   <= oor_next;
    end

    // Next state and control.
    always_comb begin
        state_next = state_reg;
        freq_next  = freq_reg;
        prev_next  = prev_reg;
        good_next  = good_reg;
        count_next = count_reg;
        semi_next  = semi_reg;
        oct_next   = oct_reg;
        oor_next   = oor_reg;
        mul_load   = 1'b0;
        mul_step   = 1'b0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    freq_next  = in_freq;
                    prev_next  = '0;
                    count_next = '0;
                    semi_next  = '0;
                    oct_next   = '0;
                    mul_load   = 1'b1;
                    oor_next   = in_freq < {{(FREQ_W-BASE_W){1'b0}}, cfg.base_freq};
                    state_next = oor_next ? ST_FINISH : ST_STEP;
                end
            end

            // One ladder step per cycle; the base note itself is not limit checked.
            ST_STEP: begin
                if (count_reg != '0 && note > {1'b0, cfg.upper_limit}) begin
                    oor_next   = 1'b1;
                    state_next = ST_FINISH;
                end else if ({1'b0, freq_reg} > note) begin
                    if (count_reg >= CNT_W'(MAX_STEPS)) begin
                        oor_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        mul_step   = 1'b1;
                        count_next = count_reg + 1'b1;
                        prev_next  = note_lo;
                        if (semi_reg == SEMI_W'(11)) begin
                            semi_next = '0;
                            oct_next  = oct_reg + 1'b1;
                        end else begin
                            semi_next = semi_reg + 1'b1;
                        end
                    end
                end else begin
                    state_next = ST_PICK;
                end
            end

            // Nearer of the two bracketing notes; a tie goes to the lower one.
            ST_PICK: begin
                if (count_reg == '0 || diff_hi < diff_lo) begin
                    good_next = note_lo;
                end else begin
                    good_next = prev_reg;
                    if (semi_reg == '0) begin
                        semi_next = SEMI_W'(11);
                        oct_next  = oct_reg - 1'b1;
                    end else begin
                        semi_next = semi_reg - 1'b1;
                    end
                end
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result fields.
    always_comb begin
        if (oor_reg) begin
            res.in_range        = 1'b0;
            res.semitone        = '0;
            res.octave          = '0;
            res.tune_up         = 1'b0;
            res.in_tune         = 1'b0;
            res.letter_char     = CHAR_DASH;
            res.accidental_char = CHAR_DASH;
            res.octave_char     = CHAR_DASH;
        end else begin
            res.in_range        = 1'b1;
            res.semitone        = semi_reg;
            res.octave          = oct_sat;
            res.tune_up         = freq_reg < good_reg;
            res.in_tune         = good_diff < {{(FREQ_W-TOL_W){1'b0}}, cfg.tune_tolerance};
            res.letter_char     = (oct_sat <= OCT_OUT_W'(2)) ? fnq_letter(semi_reg)
                                : fnq_letter(semi_reg) + CASE_SHIFT;
            res.accidental_char = fnq_sharp(semi_reg) ? CHAR_SHARP : CHAR_DASH;
            res.octave_char     = fnq_oct_digit(oct_sat);
        end
    end

endmodule

// File: hdl/frequency_to_note_quantizer_core.sv
// Top level: configuration registers, note sequencer and result output register.
//
// The block turns one measured frequency (units of 2^-16 Hz) into the nearest
// equal-tempered note above the programmed base note, with tuning flags and
// three ASCII display characters.
// Input items arrive on the s_ stream channel; result items leave on the m_
// stream channel, one result for every input item, in order.
// The APB port holds base_freq (0x0), tune_tolerance (0x4) and upper_limit
// (0x8); write it only while no item is in flight.
// An accepted item loads the base note, climbs the ladder in the step state
// until the note reaches the input, then the pick state takes the nearer note
// and the finish state offers the result; past the limit or the step cap the
// pick state is skipped, and an input below the base goes straight to finish.
// The ladder loop does one rounding multiply by 2^(1/12) and its compares per
// cycle. s_tready is high only while the sequencer is idle, so it takes a new
// item only after handing its result to the output register; while the
// receiver stalls, the sequencer already takes the next item and holds its
// result until the register frees up.
// Reset returns the registers to their defaults, drops m_tvalid and leaves
// the sequencer idle.
module frequency_to_note_quantizer_core import fnq_pkg::*; #(
    parameter int MAX_STEPS = FNQ_MAX_STEPS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,  // [29:0] frequency, [31:30] zero
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,  // [3:0] semitone, [7:4] octave, [8] tune_up,
                                            // [9] in_tune, [17:10] letter_char,
                                            // [25:18] accidental_char,
                                            // [33:26] octave_char, [39:34] zero
    output logic                  m_tuser   // [0] in_range
);

    logic [BASE_W-1:0]  base_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [LIMIT_W-1:0] limit_reg;
    fnq_cfg_t           cfg;
    fnq_reg_t           reg_sel;
    logic               cfg_wr;

    logic               res_valid;
    logic               res_ready;
    fnq_result_t        res;

    logic               m_valid_reg, m_valid_next;
    fnq_result_t        m_res_reg;

    // Register file writes.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = fnq_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_RESET;
            tol_reg   <= TOL_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_BASE_FREQ: base_reg  <= pwdata[BASE_W-1:0];
                REG_TUNE_TOL:  tol_reg   <= pwdata[TOL_W-1:0];
                REG_UPPER_LIM: limit_reg <= pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register file reads.
    always_comb begin
        case (reg_sel)
            REG_BASE_FREQ: prdata = {{(APB_DATA_W-BASE_W){1'b0}}, base_reg};
            REG_TUNE_TOL:  prdata = {{(APB_DATA_W-TOL_W){1'b0}}, tol_reg};
            REG_UPPER_LIM: prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, limit_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.base_freq      = base_reg;
    assign cfg.tune_tolerance = tol_reg;
    assign cfg.upper_limit    = limit_reg;

    fnq_seq #(
        .MAX_STEPS (MAX_STEPS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_freq   (s_tdata[FREQ_W-1:0]),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: loads when empty or when its item is taken.
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.in_range;
    assign m_tdata  = {6'b0,
                       m_res_reg.octave_char,
                       m_res_reg.accidental_char,
                       m_res_reg.letter_char,
                       m_res_reg.in_tune,
                       m_res_reg.tune_up,
                       m_res_reg.octave,
                       m_res_reg.semitone};

endmodule

// File: hdl/fnq_checker.sv
// Port-level checker for the quantizer core and its bind to the top level.
module fnq_checker import fnq_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result item stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // The sequencer is busy in the cycle after it takes an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // An out-of-range result shows dashes and zero fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[9:0] == 10'd0 && m_tdata[17:10] == CHAR_DASH
            && m_tdata[25:18] == CHAR_DASH && m_tdata[33:26] == CHAR_DASH)
        else $error("out-of-range result not blanked");

    // A found note has a semitone of C through B.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[3:0] <= 4'd11)
        else $error("semitone out of range");

endmodule

bind frequency_to_note_quantizer_core fnq_checker u_fnq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
